### design/iotpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iotpb_pkg;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [15:0] PORT_HALT = 16'h0000;
    localparam logic [15:0] PORT_COUT = 16'h0001;
    localparam logic [15:0] PORT_CLK  = 16'h0002;
    localparam logic [15:0] PORT_CTRL = 16'h0003;
    localparam logic [15:0] PORT_TVAL = 16'h0004;

    localparam int CTL_EN    = 0;
    localparam int CTL_IRQEN = 1;
    localparam int CTL_PEND  = 2;
    localparam int CTL_REP   = 3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] port;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        char_valid;
        logic [7:0]  char_out;
        logic        halt_valid;
        logic [31:0] halt_code;
    } t_result;

endpackage

`default_nettype wire

### design/iotpb_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module iotpb_in_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire iotpb_pkg::t_req i_req,
    input  wire                  i_advance,
    output logic                 o_valid,
    output iotpb_pkg::t_req      o_req
);

    logic            r_valid;
    logic            n_valid;
    iotpb_pkg::t_req r_req;
    logic            accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

`default_nettype wire

### design/iotpb_core.sv
`timescale 1ns / 1ps
`default_nettype none

module iotpb_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire iotpb_pkg::t_req i_req,
    output iotpb_pkg::t_result   o_result
);

    logic [31:0] r_cycle_count, n_cycle_count;
    logic [31:0] r_timer_count, n_timer_count;
    logic [31:0] r_reload_value, n_reload_value;
    logic [31:0] r_control_word, n_control_word;
    logic [31:0] r_read_hold, n_read_hold;

    logic        is_read;
    logic        is_write;
    logic        ctrl_wr;
    logic [31:0] cw_after_io;
    logic [31:0] tc_after_io;
    logic [31:0] tc_inc;

    assign is_read  = (i_req.req_type == iotpb_pkg::REQ_READ);
    assign is_write = (i_req.req_type == iotpb_pkg::REQ_WRITE);
    assign ctrl_wr  = is_write && (i_req.port == iotpb_pkg::PORT_CTRL);

    always_comb begin
        cw_after_io    = ctrl_wr ? i_req.write_data : r_control_word;
        // rising enable loads the reload value before the tick
        tc_after_io    = (ctrl_wr && i_req.write_data[iotpb_pkg::CTL_EN]
                          && !r_control_word[iotpb_pkg::CTL_EN])
                         ? r_reload_value : r_timer_count;
        n_reload_value = (is_write && (i_req.port == iotpb_pkg::PORT_TVAL))
                         ? i_req.write_data : r_reload_value;
        tc_inc         = tc_after_io + 32'd1;

        n_timer_count  = tc_after_io;
        n_control_word = cw_after_io;
        if (cw_after_io[iotpb_pkg::CTL_EN]) begin
            if (tc_inc == 32'd0) begin
                n_timer_count = n_reload_value;
                n_control_word[iotpb_pkg::CTL_PEND] = 1'b1;
                if (!cw_after_io[iotpb_pkg::CTL_REP]) begin
                    n_control_word[iotpb_pkg::CTL_EN] = 1'b0;
                end
            end else begin
                n_timer_count = tc_inc;
            end
        end

        // reads see state from before this tick
        n_read_hold = r_read_hold;
        if (is_read) begin
            case (i_req.port)
                iotpb_pkg::PORT_CLK:  n_read_hold = r_cycle_count;
                iotpb_pkg::PORT_CTRL: n_read_hold = r_control_word;
                iotpb_pkg::PORT_TVAL: n_read_hold = r_timer_count;
                default:              n_read_hold = r_read_hold;
            endcase
        end

        n_cycle_count = r_cycle_count + 32'd1;
    end

    always_comb begin
        o_result.read_data  = n_read_hold;
        o_result.irq        = n_control_word[iotpb_pkg::CTL_IRQEN]
                              && n_control_word[iotpb_pkg::CTL_PEND];
        o_result.char_valid = is_write && (i_req.port == iotpb_pkg::PORT_COUT);
        o_result.char_out   = o_result.char_valid ? i_req.write_data[7:0] : 8'd0;
        o_result.halt_valid = is_write && (i_req.port == iotpb_pkg::PORT_HALT);
        o_result.halt_code  = o_result.halt_valid ? i_req.write_data : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_count  <= 32'd0;
            r_timer_count  <= 32'd0;
            r_reload_value <= 32'd0;
            r_control_word <= 32'd0;
            r_read_hold    <= 32'd0;
        end else if (i_fire) begin
            r_cycle_count  <= n_cycle_count;
            r_timer_count  <= n_timer_count;
            r_reload_value <= n_reload_value;
            r_control_word <= n_control_word;
            r_read_hold    <= n_read_hold;
        end
    end

`ifndef SYNTH
    a_cycle_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> (r_cycle_count == $past(r_cycle_count) + 32'd1))
        else $error("cycle count did not advance on item");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_timer_count) && $stable(r_control_word)
                     && $stable(r_read_hold)))
        else $error("timer state changed without an item");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_result.char_valid && o_result.halt_valid))
        else $error("halt and console both flagged");

    a_wrap_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && cw_after_io[iotpb_pkg::CTL_EN] && (tc_inc == 32'd0))
        |=> r_control_word[iotpb_pkg::CTL_PEND])
        else $error("pending not set on timer wrap");
`endif

endmodule

`default_nettype wire

### design/iotpb_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module iotpb_out_stage (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_load,
    input  wire iotpb_pkg::t_result i_result,
    input  wire                     i_stall,
    output logic                    o_valid,
    output iotpb_pkg::t_result      o_result
);

    logic               r_valid;
    logic               n_valid;
    iotpb_pkg::t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### design/io_timer_port_block_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: the input register holds an accepted item until its result loads the result register.
// Throughput: one item per cycle unless a stall holds a waiting result; the timer/port
// update is a single pass of logic between the input register and the result register.
// A stall with a result waiting holds both stages; o_stall rises when a full input stage is held.
// Reset (synchronous, active low) clears the counters, reload, control,
// read data and both stage valids.
module io_timer_port_block_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [15:0] i_port,
    input  wire  [31:0] i_write_data,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_read_data,
    output logic        o_irq,
    output logic        o_char_valid,
    output logic [7:0]  o_char_out,
    output logic        o_halt_valid,
    output logic [31:0] o_halt_code
);

    iotpb_pkg::t_req    in_req;
    iotpb_pkg::t_req    stage_req;
    iotpb_pkg::t_result core_result;
    iotpb_pkg::t_result out_result;
    logic               stage_valid;
    logic               fire;

    assign in_req.req_type   = i_req_type;
    assign in_req.port       = i_port;
    assign in_req.write_data = i_write_data;

    // advance the staged item unless the result register is full and stalled
    assign fire = stage_valid && !(o_valid && i_stall);

    iotpb_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_req     (in_req),
        .i_advance (fire),
        .o_valid   (stage_valid),
        .o_req     (stage_req)
    );

    iotpb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_req    (stage_req),
        .o_result (core_result)
    );

    iotpb_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_read_data  = out_result.read_data;
    assign o_irq        = out_result.irq;
    assign o_char_valid = out_result.char_valid;
    assign o_char_out   = out_result.char_out;
    assign o_halt_valid = out_result.halt_valid;
    assign o_halt_code  = out_result.halt_code;

endmodule

`default_nettype wire
